[rtl/core/minv_pkg.sv]
// minv_pkg: shared constants, types and index helpers for the 3x3 matrix inverse unit.
// No dependencies; every other file in rtl/core refers to it by scoped names.
`timescale 1ns / 1ps

package minv_pkg;

   localparam int ELEMENT_BITS_DEF  = 32;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int TOL_BITS          = 31;
   localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(1);
   localparam int NUM_ELEMS         = 9;

   // per-lane divider status handed to the merge stage
   typedef struct packed {
      logic big;   // quotient is at least 2^ELEMENT_BITS
      logic neg;   // result is negative
      logic rnd;   // round-up bit
   } minv_lane_flags_type;

   // the two indexes out of {0,1,2} that differ from n
   function automatic int other_idx(input int n, input int k);
      return (k == 0) ? ((n == 0) ? 1 : 0) : ((n == 2) ? 1 : 2);
   endfunction

endpackage

[rtl/core/minv_front.sv]
// minv_front: cofactor products, adjugate, determinant and singular test.
// Six register stages; uses minv_pkg.
`timescale 1ns / 1ps

module minv_front #(
   parameter int E = minv_pkg::ELEMENT_BITS_DEF,
   parameter int F = minv_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [E-1:0]           a_in [minv_pkg::NUM_ELEMS],
   input  logic [minv_pkg::TOL_BITS-1:0] tol_in,
   output logic signed [2*E:0]           cof_out [minv_pkg::NUM_ELEMS],
   output logic [3*E:0]                  dmag_out,
   output logic                          dneg_out,
   output logic                          sing_out
);

   localparam int CW  = 2 * E + 1;
   localparam int DW  = 3 * E + 1;
   localparam int TW  = minv_pkg::TOL_BITS + 2 * F;
   localparam int CMW = (TW > DW) ? TW : DW;
   localparam int NE  = minv_pkg::NUM_ELEMS;

   logic signed [2*E-1:0] p_ff [NE];
   logic signed [2*E-1:0] q_ff [NE];
   logic signed [CW-1:0]  cof2_ff [NE];
   logic signed [CW-1:0]  cof3_ff [NE];
   logic signed [CW-1:0]  cof4_ff [NE];
   logic signed [CW-1:0]  cof5_ff [NE];
   logic signed [CW-1:0]  cof6_ff [NE];
   logic signed [E-1:0]   a01_ff [3];
   logic signed [E-1:0]   a02_ff [3];
   logic signed [2*E:0]   lo_ff [3];
   logic signed [2*E:0]   hi_ff [3];
   logic signed [DW-1:0]  prod_ff [3];
   logic signed [DW-1:0]  det_ff;
   logic [DW-1:0]         dmag_ff;
   logic                  dneg_ff;
   logic                  sing_ff;
   logic [DW-1:0]         dmag_in;
   logic [CMW-1:0]        thr;

   for (genvar n = 0; n < NE; n++) begin : g_cof
      localparam int I   = n / 3;
      localparam int J   = n % 3;
      localparam int R0  = minv_pkg::other_idx(J, 0);
      localparam int R1  = minv_pkg::other_idx(J, 1);
      localparam int C0  = minv_pkg::other_idx(I, 0);
      localparam int C1  = minv_pkg::other_idx(I, 1);
      localparam int ODD = (I + J) % 2;
      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[n]    <= a_in[R0*3+C0] * a_in[R1*3+C1];
            q_ff[n]    <= a_in[R0*3+C1] * a_in[R1*3+C0];
            cof2_ff[n] <= (ODD == 1) ? (CW'(q_ff[n]) - CW'(p_ff[n]))
                                     : (CW'(p_ff[n]) - CW'(q_ff[n]));
            cof3_ff[n] <= cof2_ff[n];
            cof4_ff[n] <= cof3_ff[n];
            cof5_ff[n] <= cof4_ff[n];
            cof6_ff[n] <= cof5_ff[n];
         end
      end
      assign cof_out[n] = cof6_ff[n];
   end

   // det = sum of a0k * cof(k,0); each product split on the cofactor
   for (genvar k = 0; k < 3; k++) begin : g_det
      always_ff @(posedge clock) begin
         if (en) begin
            a01_ff[k]  <= a_in[k];
            a02_ff[k]  <= a01_ff[k];
            lo_ff[k]   <= a02_ff[k] * $signed({1'b0, cof2_ff[k*3][E-1:0]});
            hi_ff[k]   <= a02_ff[k] * $signed(cof2_ff[k*3][CW-1:E]);
            prod_ff[k] <= (DW'(hi_ff[k]) <<< E) + DW'(lo_ff[k]);
         end
      end
   end

   always_comb begin
      dmag_in = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
      thr     = CMW'({tol_in, {(2*F){1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff  <= prod_ff[0] + prod_ff[1] + prod_ff[2];
         dmag_ff <= dmag_in;
         dneg_ff <= det_ff[DW-1];
         sing_ff <= (CMW'(dmag_in) <= thr);
      end
   end

   assign dmag_out = dmag_ff;
   assign dneg_out = dneg_ff;
   assign sing_out = sing_ff;

endmodule

[rtl/core/minv_lane.sv]
// minv_lane: one divider lane, |cofactor| * 2^(2F) / |det| by restoring shift and subtract,
// one quotient bit per stage plus a round bit. Uses minv_pkg.
`timescale 1ns / 1ps

module minv_lane #(
   parameter int E = minv_pkg::ELEMENT_BITS_DEF,
   parameter int F = minv_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [2*E:0]           cof_in,
   input  logic [3*E:0]                  dmag_in,
   input  logic                          dneg_in,
   output logic [E-1:0]                  quot_out,
   output minv_pkg::minv_lane_flags_type flags_out
);

   localparam int CW = 2 * E + 1;
   localparam int DW = 3 * E + 1;
   localparam int NW = CW + 2 * F;
   localparam int TW = NW - E;
   localparam int MW = (TW > DW) ? TW : DW;
   localparam int NS = E + 1;

   logic [CW-1:0] mag_ff;
   logic          negp_ff;
   logic [DW-1:0] dp_ff;

   logic [DW-1:0] r_ff   [NS+1];
   logic [E-1:0]  nlo_ff [NS+1];
   logic [DW-1:0] d_ff   [NS+1];
   logic [NS-1:0] q_ff   [NS+1];
   logic          big_ff [NS+1];
   logic          neg_ff [NS+1];

   logic [NW-1:0] num;
   logic [MW-1:0] top;
   logic          big_in;

   always_comb begin
      num    = {mag_ff, {(2*F){1'b0}}};
      top    = MW'(num[NW-1:E]);
      big_in = (top >= MW'(dp_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff    <= cof_in[CW-1] ? CW'(-cof_in) : CW'(cof_in);
         negp_ff   <= cof_in[CW-1] ^ dneg_in;
         dp_ff     <= dmag_in;
         // quotient too large: the remainder is irrelevant, start from zero
         r_ff[0]   <= big_in ? '0 : top[DW-1:0];
         nlo_ff[0] <= num[E-1:0];
         d_ff[0]   <= dp_ff;
         q_ff[0]   <= '0;
         big_ff[0] <= big_in;
         neg_ff[0] <= negp_ff;
      end
   end

   for (genvar s = 1; s <= NS; s++) begin : g_iter
      logic [DW:0] rem_sh;
      logic [DW:0] diff;
      logic        ge;
      always_comb begin
         rem_sh = {r_ff[s-1], nlo_ff[s-1][E-1]};
         diff   = rem_sh - {1'b0, d_ff[s-1]};
         ge     = (rem_sh >= {1'b0, d_ff[s-1]});
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]   <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            nlo_ff[s] <= nlo_ff[s-1] << 1;
            d_ff[s]   <= d_ff[s-1];
            q_ff[s]   <= {q_ff[s-1][NS-2:0], ge};
            big_ff[s] <= big_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
         end
      end
   end

   assign quot_out      = q_ff[NS][NS-1:1];
   assign flags_out.big = big_ff[NS];
   assign flags_out.neg = neg_ff[NS];
   assign flags_out.rnd = q_ff[NS][0];

endmodule

[rtl/core/minv_merge.sv]
// minv_merge: rounds and saturates the nine lane quotients, applies sign and the
// identity for singular matrices, and ORs the overflow flags. Uses minv_pkg.
`timescale 1ns / 1ps

module minv_merge #(
   parameter int E = minv_pkg::ELEMENT_BITS_DEF,
   parameter int F = minv_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [E-1:0]                  quot_in  [minv_pkg::NUM_ELEMS],
   input  minv_pkg::minv_lane_flags_type flags_in [minv_pkg::NUM_ELEMS],
   input  logic                          sing_in,
   output logic signed [E-1:0]           r_out    [minv_pkg::NUM_ELEMS],
   output logic                          sing_out,
   output logic                          ovf_out
);

   localparam int NE = minv_pkg::NUM_ELEMS;
   localparam logic IDENT_OVF = (F >= E - 1);
   localparam logic [E-1:0] MAXPOS = {1'b0, {(E-1){1'b1}}};
   localparam logic [E-1:0] ONE = IDENT_OVF ? MAXPOS : (E'(1) << (F % E));
   localparam logic [E:0] LIM_POS = (E+1)'(MAXPOS);
   localparam logic [E:0] LIM_NEG = (E+1)'(MAXPOS) + (E+1)'(1);

   logic signed [E-1:0] r_ff [NE];
   logic                sing_ff;
   logic                ovf_ff;
   logic [E-1:0]        r_in [NE];
   logic [NE-1:0]       sat;

   for (genvar n = 0; n < NE; n++) begin : g_lane
      logic [E:0] qr;
      logic [E:0] lim;
      logic [E:0] mag;
      logic [E:0] val;
      always_comb begin
         qr     = {1'b0, quot_in[n]} + (E+1)'(flags_in[n].rnd);
         lim    = flags_in[n].neg ? LIM_NEG : LIM_POS;
         sat[n] = flags_in[n].big || (qr > lim);
         mag    = sat[n] ? lim : qr;
         val    = flags_in[n].neg ? -mag : mag;
         if (sing_in) begin
            r_in[n] = ((n / 3) == (n % 3)) ? ONE : '0;
         end else begin
            r_in[n] = val[E-1:0];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[n] <= $signed(r_in[n]);
         end
      end
      assign r_out[n] = r_ff[n];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff <= sing_in;
         ovf_ff  <= sing_in ? IDENT_OVF : (|sat);
      end
   end

   assign sing_out = sing_ff;
   assign ovf_out  = ovf_ff;

endmodule

[rtl/core/matrix3x3_inverse_unit.sv]
// matrix3x3_inverse_unit: top level of the 3x3 fixed-point matrix inverse.
// Instantiates minv_front, nine minv_lane dividers and minv_merge; uses minv_pkg.
//
// Usage:
//   req_ channel carries one matrix word (a00..a22, signed, FRACTION_BITS fraction
//   bits). A word is taken on a clock edge with req_valid high and req_stall low.
//   rsp_ channel returns one word per matrix: r00..r22, rsp_singular and
//   rsp_overflow, handed over on an edge with rsp_valid high and rsp_stall low.
//   csr_ channel writes singular_tolerance; csr_ready is always high. Write it only
//   while the pipeline is empty.
// Stages from accept to rsp_valid: six front stages for cofactors and determinant,
//   ELEMENT_BITS + 3 stages in each divider lane (one quotient bit per iteration
//   stage, plus a round bit), one merge/output stage.
// Throughput: one matrix per cycle unless stalled; the lanes are fully pipelined.
// Stall: when the output word is held, the whole pipeline freezes and req_stall
//   rises in the same cycle; nothing is dropped.
// Reset: synchronous, clears all valid flags and sets the tolerance to 1 LSB.
`timescale 1ns / 1ps

module matrix3x3_inverse_unit #(
   parameter int ELEMENT_BITS  = minv_pkg::ELEMENT_BITS_DEF,
   parameter int FRACTION_BITS = minv_pkg::FRACTION_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [ELEMENT_BITS-1:0]   req_a00,
   input  logic signed [ELEMENT_BITS-1:0]   req_a01,
   input  logic signed [ELEMENT_BITS-1:0]   req_a02,
   input  logic signed [ELEMENT_BITS-1:0]   req_a10,
   input  logic signed [ELEMENT_BITS-1:0]   req_a11,
   input  logic signed [ELEMENT_BITS-1:0]   req_a12,
   input  logic signed [ELEMENT_BITS-1:0]   req_a20,
   input  logic signed [ELEMENT_BITS-1:0]   req_a21,
   input  logic signed [ELEMENT_BITS-1:0]   req_a22,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [ELEMENT_BITS-1:0]   rsp_r00,
   output logic signed [ELEMENT_BITS-1:0]   rsp_r01,
   output logic signed [ELEMENT_BITS-1:0]   rsp_r02,
   output logic signed [ELEMENT_BITS-1:0]   rsp_r10,
   output logic signed [ELEMENT_BITS-1:0]   rsp_r11,
   output logic signed [ELEMENT_BITS-1:0]   rsp_r12,
   output logic signed [ELEMENT_BITS-1:0]   rsp_r20,
   output logic signed [ELEMENT_BITS-1:0]   rsp_r21,
   output logic signed [ELEMENT_BITS-1:0]   rsp_r22,
   output logic                             rsp_singular,
   output logic                             rsp_overflow,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [minv_pkg::TOL_BITS-1:0]    csr_singular_tolerance
);

   localparam int E        = ELEMENT_BITS;
   localparam int NE       = minv_pkg::NUM_ELEMS;
   localparam int LANE_LAT = E + 3;
   localparam int LAT      = E + 10;

   logic                          en;
   logic [LAT-1:0]                vld_ff;
   logic [LANE_LAT-1:0]           sing_dly_ff;
   logic [minv_pkg::TOL_BITS-1:0] tol_ff;

   logic signed [E-1:0]           a [NE];
   logic signed [2*E:0]           cof [NE];
   logic [3*E:0]                  dmag;
   logic                          dneg;
   logic                          sing;
   logic [E-1:0]                  quot [NE];
   minv_pkg::minv_lane_flags_type flags [NE];
   logic signed [E-1:0]           r [NE];

   // pipeline moves unless a finished word is held at the output
   assign en        = !vld_ff[LAT-1] || !rsp_stall;
   assign req_stall = !en;
   assign csr_ready = 1'b1;
   assign rsp_valid = vld_ff[LAT-1];

   assign a[0] = req_a00;
   assign a[1] = req_a01;
   assign a[2] = req_a02;
   assign a[3] = req_a10;
   assign a[4] = req_a11;
   assign a[5] = req_a12;
   assign a[6] = req_a20;
   assign a[7] = req_a21;
   assign a[8] = req_a22;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         tol_ff <= minv_pkg::TOL_RESET;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[LAT-2:0], req_valid};
         end
         if (csr_valid && csr_ready) begin
            tol_ff <= csr_singular_tolerance;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sing_dly_ff <= {sing_dly_ff[LANE_LAT-2:0], sing};
      end
   end

   minv_front #(.E(E), .F(FRACTION_BITS)) u_front (
      .clock    (clock),
      .en       (en),
      .a_in     (a),
      .tol_in   (tol_ff),
      .cof_out  (cof),
      .dmag_out (dmag),
      .dneg_out (dneg),
      .sing_out (sing)
   );

   for (genvar n = 0; n < NE; n++) begin : g_lane
      minv_lane #(.E(E), .F(FRACTION_BITS)) u_lane (
         .clock     (clock),
         .en        (en),
         .cof_in    (cof[n]),
         .dmag_in   (dmag),
         .dneg_in   (dneg),
         .quot_out  (quot[n]),
         .flags_out (flags[n])
      );
   end

   minv_merge #(.E(E), .F(FRACTION_BITS)) u_merge (
      .clock    (clock),
      .en       (en),
      .quot_in  (quot),
      .flags_in (flags),
      .sing_in  (sing_dly_ff[LANE_LAT-1]),
      .r_out    (r),
      .sing_out (rsp_singular),
      .ovf_out  (rsp_overflow)
   );

   assign rsp_r00 = r[0];
   assign rsp_r01 = r[1];
   assign rsp_r02 = r[2];
   assign rsp_r10 = r[3];
   assign rsp_r11 = r[4];
   assign rsp_r12 = r[5];
   assign rsp_r20 = r[6];
   assign rsp_r21 = r[7];
   assign rsp_r22 = r[8];

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_stall_path: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow held output word");

   a_ident_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_overflow == (FRACTION_BITS >= ELEMENT_BITS - 1))
      else $error("overflow flag wrong on identity word");

   a_ident_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_r01 == '0 && rsp_r10 == '0 && rsp_r21 == '0)
      else $error("identity word has nonzero off-diagonal");

endmodule
